[rtl/core/diff_drive_wheel_speed_ramp_defines.svh]
// assertion macros used by the wheel speed ramp port checker
`ifndef DIFF_DRIVE_WHEEL_SPEED_RAMP_DEFINES_SVH
`define DIFF_DRIVE_WHEEL_SPEED_RAMP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define DDWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property checked on every rising clock edge, reset included
`define DDWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/ddws_pkg.sv]
// types and constants of the differential drive wheel speed ramp
`timescale 1ns / 1ps
`default_nettype none

package ddws_pkg;

  // field and register widths
  localparam int unsigned RAD_W      = 21;
  localparam int unsigned BASE_W     = 11;
  localparam int unsigned LIMIT_W    = 20;
  localparam int unsigned MSPD_W     = 14;
  localparam int unsigned ACCEL_W    = 14;
  localparam int unsigned MST_W      = 16;
  localparam int unsigned HALF_W     = MST_W - 1;
  localparam int unsigned OUT_SPD_W  = 14;
  localparam int unsigned TIME_W     = 15;
  localparam int unsigned MAG_W      = 20;
  localparam int unsigned DVS_W      = 21;
  localparam int unsigned MUL_B_W    = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // ms per second over the 0.1 cm/s speed unit
  localparam int unsigned TIME_SCALE = 100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MSPD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MST   = 3'd4;

  // register reset values
  localparam logic [BASE_W-1:0]  RST_BASE  = 11'd300;
  localparam logic [LIMIT_W-1:0] RST_LIMIT = 20'd10000;
  localparam logic [MSPD_W-1:0]  RST_MSPD  = 14'd1000;
  localparam logic [ACCEL_W-1:0] RST_ACCEL = 14'd50;
  localparam logic [MST_W-1:0]   RST_MST   = 16'd1000;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [LIMIT_W-1:0] limit;
    logic [MSPD_W-1:0]  mspd;
    logic [ACCEL_W-1:0] accel;
    logic [MST_W-1:0]   mst;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RAMP,
    ST_HOLD
  } state_e;

  typedef enum logic [2:0] {
    OP_OUTER,
    OP_INNER,
    OP_TIME_R,
    OP_TIME_L,
    OP_STEP
  } op_e;

endpackage

`default_nettype wire

[rtl/core/ddws_div.sv]
// shared radix-4 restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module ddws_div #(
  parameter int unsigned DVD_W = 40,
  parameter int unsigned DVS_W = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned ITER  = (DVD_W + 1) / 2;
  localparam int unsigned QW    = 2 * ITER;
  localparam int unsigned CNT_W = $clog2(ITER + 1);

  logic [DVS_W-1:0] rem_q;
  logic [QW-1:0]    quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  logic [DVS_W:0]   tmp1, tmp2;
  logic             ge1, ge2;
  logic [DVS_W-1:0] rem1, rem2;
  logic [QW-1:0]    quo1, quo2;

  // two dependent compare and subtract steps
  always_comb begin
    tmp1 = {rem_q, quo_q[QW-1]};
    ge1  = tmp1 >= {1'b0, dvs_q};
    rem1 = ge1 ? DVS_W'(tmp1 - {1'b0, dvs_q}) : tmp1[DVS_W-1:0];
    quo1 = {quo_q[QW-2:0], ge1};
    tmp2 = {rem1, quo1[QW-1]};
    ge2  = tmp2 >= {1'b0, dvs_q};
    rem2 = ge2 ? DVS_W'(tmp2 - {1'b0, dvs_q}) : tmp2[DVS_W-1:0];
    quo2 = {quo1[QW-2:0], ge2};
  end

  // iteration counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(ITER);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= QW'(dividend_i);
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem2;
      quo_q <= quo2;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DVD_W-1:0];

endmodule

`default_nettype wire

[rtl/core/ddws_core.sv]
// sequencer and datapath around the shared multiplier and divider
`timescale 1ns / 1ps
`default_nettype none

module ddws_core import ddws_pkg::*; #(
  parameter int unsigned SPEED_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [RAD_W-1:0] turn_radius_i,
  input  cfg_t                    cfg_i,
  input  logic                    take_i,
  output core_sts_t               sts_o,
  output logic signed [RAD_W-1:0] applied_radius_o,
  output logic [OUT_SPD_W-1:0]    right_speed_o,
  output logic [OUT_SPD_W-1:0]    left_speed_o,
  output logic [TIME_W-1:0]       right_ramp_ms_o,
  output logic [TIME_W-1:0]       left_ramp_ms_o
);

  localparam int unsigned MUL_A_W = (SPEED_BITS > MAG_W) ? SPEED_BITS : MAG_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [RAD_W-1:0]      raw_q;
  logic                  neg_q;
  logic [MAG_W-1:0]      mag_q;
  logic [PROD_W-1:0]     prod_q;
  logic [DVS_W-1:0]      dvs_q;
  logic [ACCEL_W-1:0]    addend_q;
  logic [SPEED_BITS-1:0] outer_q, inner_q, step_q;
  logic [SPEED_BITS-1:0] prev_r_q, prev_l_q;
  logic                  keep_r_q, keep_l_q, clt_r_q, clt_l_q;
  logic [TIME_W-1:0]     t_r_q, t_l_q;
  logic [RAD_W-1:0]      res_rad_q;
  logic [OUT_SPD_W-1:0]  res_rs_q, res_ls_q;
  logic [TIME_W-1:0]     res_rt_q, res_lt_q;

  logic ld_mag, ld_prod, div_start, wb, ld_res;

  logic [RAD_W-1:0]      mag_full;
  logic [MAG_W-1:0]      mag_clamp;
  logic [HALF_W-1:0]     half;
  logic [SPEED_BITS-1:0] tgt_r, tgt_l, dv_r, dv_l;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod;
  logic [DVS_W-1:0]      dvs_d;
  logic [ACCEL_W-1:0]    addend_d;
  logic                  div_done;
  logic [PROD_W-1:0]     quo;
  logic [PROD_W-1:0]     sat_src;
  logic [SPEED_BITS-1:0] quo_sat;
  logic                  accel_zero;
  logic [SPEED_BITS-1:0] spd_r, spd_l;
  logic [TIME_W-1:0]     time_r, time_l;
  logic [RAD_W-1:0]      applied;

  // speed after the ramp rules for one wheel
  function automatic logic [SPEED_BITS-1:0] ramp_speed(
    input logic [SPEED_BITS-1:0] prev,
    input logic [SPEED_BITS-1:0] tgt,
    input logic [SPEED_BITS-1:0] acc_step,
    input logic                  keep,
    input logic                  clt
  );
    logic [SPEED_BITS:0]   up;
    logic [SPEED_BITS-1:0] res;
    up = {1'b0, prev} + {1'b0, acc_step};
    if (keep) begin
      res = prev;
    end else if (clt) begin
      if (tgt > prev) begin
        res = up[SPEED_BITS] ? SPEED_MAX : up[SPEED_BITS-1:0];
      end else begin
        res = (acc_step > prev) ? '0 : prev - acc_step;
      end
    end else begin
      res = tgt;
    end
    return res;
  endfunction

  // radius magnitude and clamp
  always_comb begin
    mag_full = raw_q[RAD_W-1] ? (~raw_q + RAD_W'(1)) : raw_q;
    if (mag_full < RAD_W'(cfg_i.base)) begin
      mag_clamp = MAG_W'(cfg_i.base);
    end else if (mag_full > RAD_W'(cfg_i.limit)) begin
      mag_clamp = MAG_W'(cfg_i.limit);
    end else begin
      mag_clamp = mag_full[MAG_W-1:0];
    end
  end

  // wheel targets and speed deltas
  assign half  = cfg_i.mst[MST_W-1:1];
  assign tgt_r = neg_q ? inner_q : outer_q;
  assign tgt_l = neg_q ? outer_q : inner_q;
  assign dv_r  = (tgt_r > prev_r_q) ? tgt_r - prev_r_q : prev_r_q - tgt_r;
  assign dv_l  = (tgt_l > prev_l_q) ? tgt_l - prev_l_q : prev_l_q - tgt_l;
  assign accel_zero = (cfg_i.accel == '0);

  // operand select for the shared multiplier and divider
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    dvs_d    = '0;
    addend_d = '0;
    case (op_q)
      OP_OUTER: begin
        mul_a = MUL_A_W'(cfg_i.mspd);
        mul_b = mag_q;
        dvs_d = DVS_W'(cfg_i.limit);
      end
      OP_INNER: begin
        mul_a = MUL_A_W'(outer_q);
        mul_b = mag_q - MAG_W'(cfg_i.base);
        dvs_d = DVS_W'(mag_q) + DVS_W'(cfg_i.base);
      end
      OP_TIME_R: begin
        mul_a    = MUL_A_W'(dv_r);
        mul_b    = MUL_B_W'(TIME_SCALE);
        dvs_d    = DVS_W'(cfg_i.accel);
        addend_d = accel_zero ? '0 : cfg_i.accel - ACCEL_W'(1);
      end
      OP_TIME_L: begin
        mul_a    = MUL_A_W'(dv_l);
        mul_b    = MUL_B_W'(TIME_SCALE);
        dvs_d    = DVS_W'(cfg_i.accel);
        addend_d = accel_zero ? '0 : cfg_i.accel - ACCEL_W'(1);
      end
      OP_STEP: begin
        mul_a = MUL_A_W'(cfg_i.accel);
        mul_b = MUL_B_W'(half);
        dvs_d = DVS_W'(TIME_SCALE);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // shared divider
  ddws_div #(
    .DVD_W (PROD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q + PROD_W'(addend_q)),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // saturate a quotient to the speed range
  assign sat_src = (op_q == OP_OUTER && cfg_i.limit == '0) ? PROD_W'(cfg_i.mspd) : quo;
  assign quo_sat = (|sat_src[PROD_W-1:SPEED_BITS]) ? SPEED_MAX
                                                    : sat_src[SPEED_BITS-1:0];

  // final speeds, times and radius
  assign spd_r   = ramp_speed(prev_r_q, tgt_r, step_q, keep_r_q, clt_r_q);
  assign spd_l   = ramp_speed(prev_l_q, tgt_l, step_q, keep_l_q, clt_l_q);
  assign time_r  = (keep_r_q || clt_r_q) ? half : t_r_q;
  assign time_l  = (keep_l_q || clt_l_q) ? half : t_l_q;
  assign applied = neg_q ? (~RAD_W'(mag_q) + RAD_W'(1)) : RAD_W'(mag_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (start_i) state_d = ST_CLAMP;
      ST_CLAMP:     state_d = ST_MUL;
      ST_MUL:       state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (op_q == OP_STEP) ? ST_RAMP : ST_MUL;
        end
      end
      ST_RAMP:      state_d = ST_HOLD;
      ST_HOLD:      if (take_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // next operation in the fixed order
  always_comb begin
    case (op_q)
      OP_OUTER:  op_d = OP_INNER;
      OP_INNER:  op_d = OP_TIME_R;
      OP_TIME_R: op_d = OP_TIME_L;
      OP_TIME_L: op_d = OP_STEP;
      default:   op_d = OP_OUTER;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ld_mag          = (state_q == ST_CLAMP);
    ld_prod         = (state_q == ST_MUL);
    div_start       = (state_q == ST_DIV_START);
    wb              = (state_q == ST_DIV_WAIT) && div_done;
    ld_res          = (state_q == ST_RAMP);
    sts_o.idle      = (state_q == ST_IDLE);
    sts_o.res_valid = (state_q == ST_HOLD);
  end

  // control state and previous speeds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_OUTER;
      prev_r_q <= '0;
      prev_l_q <= '0;
    end else begin
      state_q <= state_d;
      if (start_i && state_q == ST_IDLE) begin
        op_q <= OP_OUTER;
      end else if (wb) begin
        op_q <= op_d;
      end
      if (ld_res) begin
        prev_r_q <= spd_r;
        prev_l_q <= spd_l;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i && state_q == ST_IDLE) begin
      raw_q <= $unsigned(turn_radius_i);
      neg_q <= turn_radius_i[RAD_W-1];
    end
    if (ld_mag) begin
      mag_q <= mag_clamp;
    end
    if (ld_prod) begin
      prod_q   <= prod;
      dvs_q    <= dvs_d;
      addend_q <= addend_d;
    end
    if (wb) begin
      case (op_q)
        OP_OUTER: outer_q <= quo_sat;
        OP_INNER: inner_q <= (mag_q <= MAG_W'(cfg_i.base)) ? '0 : quo[SPEED_BITS-1:0];
        OP_TIME_R: begin
          keep_r_q <= accel_zero ? (dv_r == '0) : (quo <= PROD_W'(1));
          clt_r_q  <= accel_zero ? (dv_r != '0) : (quo > PROD_W'(half));
          t_r_q    <= quo[TIME_W-1:0];
        end
        OP_TIME_L: begin
          keep_l_q <= accel_zero ? (dv_l == '0) : (quo <= PROD_W'(1));
          clt_l_q  <= accel_zero ? (dv_l != '0) : (quo > PROD_W'(half));
          t_l_q    <= quo[TIME_W-1:0];
        end
        OP_STEP:  step_q <= quo_sat;
        default:  step_q <= step_q;
      endcase
    end
    if (ld_res) begin
      res_rad_q <= applied;
      res_rs_q  <= OUT_SPD_W'(spd_r);
      res_ls_q  <= OUT_SPD_W'(spd_l);
      res_rt_q  <= time_r;
      res_lt_q  <= time_l;
    end
  end

  assign applied_radius_o = $signed(res_rad_q);
  assign right_speed_o    = res_rs_q;
  assign left_speed_o     = res_ls_q;
  assign right_ramp_ms_o  = res_rt_q;
  assign left_ramp_ms_o   = res_lt_q;

endmodule

`default_nettype wire

[rtl/core/diff_drive_wheel_speed_ramp.sv]
// Differential drive wheel speed ramp. Each turn radius transfer is clamped
// in magnitude to [base_radius, straight_radius_limit], turned into outer and
// inner wheel speeds, and given a half S-curve ramp time per wheel, with the
// previous wheel speeds kept as state. Each item makes five passes through the
// one radix-4 divider (outer speed, inner speed, two ramp times, the clamped
// speed step), each fed by a registered product of the shared multiplier. The
// input is stalled while an item is in work; a finished result waits in the
// output register so the next item can be taken meanwhile. The user must write
// the configuration registers only while the block is idle; the block itself
// does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_wheel_speed_ramp import ddws_pkg::*; #(
  parameter int unsigned SPEED_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [RAD_W-1:0] turn_radius_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [RAD_W-1:0] applied_radius_o,
  output logic [OUT_SPD_W-1:0]    right_speed_o,
  output logic [OUT_SPD_W-1:0]    left_speed_o,
  output logic [TIME_W-1:0]       right_ramp_ms_o,
  output logic [TIME_W-1:0]       left_ramp_ms_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  cfg_t      cfg_q;
  core_sts_t core_sts;
  logic      in_xfer, take;
  logic      out_valid_q;

  logic signed [RAD_W-1:0] core_rad;
  logic [OUT_SPD_W-1:0]    core_rs, core_ls;
  logic [TIME_W-1:0]       core_rt, core_lt;

  logic signed [RAD_W-1:0] rad_q;
  logic [OUT_SPD_W-1:0]    rs_q, ls_q;
  logic [TIME_W-1:0]       rt_q, lt_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= RST_BASE;
      cfg_q.limit <= RST_LIMIT;
      cfg_q.mspd  <= RST_MSPD;
      cfg_q.accel <= RST_ACCEL;
      cfg_q.mst   <= RST_MST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:  cfg_q.base  <= cfg_data_i[BASE_W-1:0];
        CFG_LIMIT: cfg_q.limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_MSPD:  cfg_q.mspd  <= cfg_data_i[MSPD_W-1:0];
        CFG_ACCEL: cfg_q.accel <= cfg_data_i[ACCEL_W-1:0];
        CFG_MST:   cfg_q.mst   <= cfg_data_i[MST_W-1:0];
        default:   cfg_q       <= cfg_q;
      endcase
    end
  end

  // input transfer and result hand-off
  assign in_stall_o = !core_sts.idle;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign take       = core_sts.res_valid && (!out_valid_q || !out_stall_i);

  ddws_core #(
    .SPEED_BITS (SPEED_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (in_xfer),
    .turn_radius_i    (turn_radius_i),
    .cfg_i            (cfg_q),
    .take_i           (take),
    .sts_o            (core_sts),
    .applied_radius_o (core_rad),
    .right_speed_o    (core_rs),
    .left_speed_o     (core_ls),
    .right_ramp_ms_o  (core_rt),
    .left_ramp_ms_o   (core_lt)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      rad_q <= core_rad;
      rs_q  <= core_rs;
      ls_q  <= core_ls;
      rt_q  <= core_rt;
      lt_q  <= core_lt;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign applied_radius_o = rad_q;
  assign right_speed_o    = rs_q;
  assign left_speed_o     = ls_q;
  assign right_ramp_ms_o  = rt_q;
  assign left_ramp_ms_o   = lt_q;

endmodule

`default_nettype wire

[rtl/core/ddws_checker.sv]
// port level checks of the wheel speed ramp and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "diff_drive_wheel_speed_ramp_defines.svh"

module ddws_checker import ddws_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [RAD_W-1:0] applied_radius_o,
  input logic [OUT_SPD_W-1:0]    right_speed_o,
  input logic [OUT_SPD_W-1:0]    left_speed_o,
  input logic [TIME_W-1:0]       right_ramp_ms_o,
  input logic [TIME_W-1:0]       left_ramp_ms_o
);

  logic       in_xfer, out_xfer;
  logic [1:0] cnt_q, cnt_d;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // items taken in and not yet delivered
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // stalled result holds
  `DDWS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(applied_radius_o) && $stable(right_speed_o) && $stable(left_speed_o) && $stable(right_ramp_ms_o) && $stable(left_ramp_ms_o), "stalled result changed")

  // an accepted item keeps the block busy in the cycle after the transfer
  `DDWS_ASSERT(a_busy_after_xfer, in_xfer |=> in_stall_o, "input taken right after a transfer")

  // one item in work and one waiting fill the block
  `DDWS_ASSERT(a_full_stalls, cnt_q == 2'd2 |-> in_stall_o, "input open with two items held")

  // no result without an item taken
  `DDWS_ASSERT(a_no_phantom, out_valid_o |-> cnt_q != 2'd0, "result shown with no item taken")

  // reset leaves the block empty and open
  `DDWS_ASSERT_ALWAYS(a_rst_clear, !rst_ni |-> !out_valid_o && !in_stall_o, "block not clear in reset")

endmodule

bind diff_drive_wheel_speed_ramp ddws_checker u_ddws_checker (.*);

`default_nettype wire

[test/diff_drive_wheel_speed_ramp_checker.sv]
// checker for the wheel speed ramp: predicts each result and compares the outputs
`timescale 1ns / 1ps

module diff_drive_wheel_speed_ramp_checker import ddws_pkg::*; #(
  parameter int unsigned SPEED_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [RAD_W-1:0]      turn_radius_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [RAD_W-1:0]      applied_radius_i,
  input  logic [OUT_SPD_W-1:0]  right_speed_i,
  input  logic [OUT_SPD_W-1:0]  left_speed_i,
  input  logic [TIME_W-1:0]     right_ramp_ms_i,
  input  logic [TIME_W-1:0]     left_ramp_ms_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam longint unsigned SPEED_MAX = (64'd1 << SPEED_BITS) - 64'd1;
  localparam longint unsigned TIME_SAT  = 64'hFFFF_FFFF;
  localparam int              MAX_REPORTS = 100;

  // one wheel command as the block should produce it, with the radius that caused it
  typedef struct packed {
    logic [RAD_W-1:0]     turn;
    logic [RAD_W-1:0]     radius;
    logic [OUT_SPD_W-1:0] right_speed;
    logic [OUT_SPD_W-1:0] left_speed;
    logic [TIME_W-1:0]    right_ms;
    logic [TIME_W-1:0]    left_ms;
  } wheel_cmd_t;

  typedef struct packed {
    logic [63:0] speed;
    logic [63:0] ms;
  } ramp_t;

  cfg_t                  cfg_q;
  logic [SPEED_BITS-1:0] prev_right_q;
  logic [SPEED_BITS-1:0] prev_left_q;
  wheel_cmd_t            expected_cmds[$];

  // half s-curve time and the speed actually reached for one wheel
  function automatic ramp_t ramp_wheel_speed(input longint unsigned prev,
                                             input longint unsigned target);
    longint unsigned dv, half, acc, t, step, v;
    ramp_t res;
    dv   = (target > prev) ? target - prev : prev - target;
    half = longint'(cfg_q.mst) >> 1;
    acc  = 64'(cfg_q.accel);
    if (acc == 0) t = (dv == 0) ? 0 : TIME_SAT;
    else t = (TIME_SCALE * dv + acc - 1) / acc;
    res.speed = target;
    res.ms    = t;
    if (t <= 1) begin
      // change too small to ramp: hold the old speed
      res.speed = prev;
      res.ms    = half;
    end else if (t > half) begin
      // ramp too long: clamp the time, go at max acceleration
      step = (acc * half) / TIME_SCALE;
      if (target > prev) begin
        v = prev + step;
        res.speed = (v > SPEED_MAX) ? SPEED_MAX : v;
      end else begin
        res.speed = (step > prev) ? 0 : prev - step;
      end
      res.ms = half;
    end
    return res;
  endfunction

  // wheel command for one turn radius, advances the previous speeds
  function automatic wheel_cmd_t predict_wheel_cmd(input logic [RAD_W-1:0] raw);
    logic             neg;
    logic [RAD_W-1:0] neg_raw, mag_bits;
    longint unsigned  mag, b, lim, spd, outer, inner, rs, ls;
    ramp_t            rr, lr;
    wheel_cmd_t       cmd;
    neg     = raw[RAD_W-1];
    neg_raw = -raw;
    mag     = 64'(neg ? neg_raw : raw);
    b       = 64'(cfg_q.base);
    lim     = 64'(cfg_q.limit);
    spd     = 64'(cfg_q.mspd);
    // minimum clamp first, so a base above the limit wins
    if (mag < b) mag = b;
    else if (mag > lim) mag = lim;
    outer = (lim == 0) ? spd : (spd * mag) / lim;
    if (outer > SPEED_MAX) outer = SPEED_MAX;
    if (mag <= b || mag + b == 0) inner = 0;
    else inner = (outer * (mag - b)) / (mag + b);
    // clockwise turns put the outer wheel on the left
    if (neg) begin
      ls = outer;
      rs = inner;
    end else begin
      rs = outer;
      ls = inner;
    end
    rr = ramp_wheel_speed(64'(prev_right_q), rs);
    lr = ramp_wheel_speed(64'(prev_left_q), ls);
    prev_right_q = rr.speed[SPEED_BITS-1:0];
    prev_left_q  = lr.speed[SPEED_BITS-1:0];
    mag_bits        = mag[RAD_W-1:0];
    cmd.turn        = raw;
    cmd.radius      = neg ? -mag_bits : mag_bits;
    cmd.right_speed = rr.speed[OUT_SPD_W-1:0];
    cmd.left_speed  = lr.speed[OUT_SPD_W-1:0];
    cmd.right_ms    = rr.ms[TIME_W-1:0];
    cmd.left_ms     = lr.ms[TIME_W-1:0];
    return cmd;
  endfunction

  task automatic report_field(input string field, input logic [RAD_W-1:0] turn,
                              input longint exp_v, input longint act_v);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS)
      $display("%0t: %s for turn radius %0d: expected %0d, got %0d",
               $time, field, $signed(turn), exp_v, act_v);
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    wheel_cmd_t exp_cmd;
    if (!rst_ni) begin
      cfg_q        = '{base: RST_BASE, limit: RST_LIMIT, mspd: RST_MSPD,
                       accel: RST_ACCEL, mst: RST_MST};
      prev_right_q = '0;
      prev_left_q  = '0;
      fail_count_o = 0;
      pending_o    = 0;
      expected_cmds.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_cmds.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: result with nothing expected: radius %0d right %0d left %0d",
                     $time, $signed(applied_radius_i), right_speed_i, left_speed_i);
        end else begin
          exp_cmd = expected_cmds.pop_front();
          if (applied_radius_i !== exp_cmd.radius)
            report_field("applied_radius", exp_cmd.turn,
                         longint'($signed(exp_cmd.radius)),
                         longint'($signed(applied_radius_i)));
          if (right_speed_i !== exp_cmd.right_speed)
            report_field("right_speed", exp_cmd.turn, longint'(exp_cmd.right_speed),
                         longint'(right_speed_i));
          if (left_speed_i !== exp_cmd.left_speed)
            report_field("left_speed", exp_cmd.turn, longint'(exp_cmd.left_speed),
                         longint'(left_speed_i));
          if (right_ramp_ms_i !== exp_cmd.right_ms)
            report_field("right_ramp_ms", exp_cmd.turn, longint'(exp_cmd.right_ms),
                         longint'(right_ramp_ms_i));
          if (left_ramp_ms_i !== exp_cmd.left_ms)
            report_field("left_ramp_ms", exp_cmd.turn, longint'(exp_cmd.left_ms),
                         longint'(left_ramp_ms_i));
        end
      end
      // input transfer
      if (in_valid_i && !in_stall_i)
        expected_cmds.push_back(predict_wheel_cmd(turn_radius_i));
      // register writes, masked to the register widths
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE:  cfg_q.base  = cfg_data_i[BASE_W-1:0];
          CFG_LIMIT: cfg_q.limit = cfg_data_i[LIMIT_W-1:0];
          CFG_MSPD:  cfg_q.mspd  = cfg_data_i[MSPD_W-1:0];
          CFG_ACCEL: cfg_q.accel = cfg_data_i[ACCEL_W-1:0];
          CFG_MST:   cfg_q.mst   = cfg_data_i[MST_W-1:0];
          default: ;
        endcase
      end
      pending_o = expected_cmds.size();
    end
  end

endmodule

[test/diff_drive_wheel_speed_ramp_tb.sv]
// testbench top for the wheel speed ramp: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module diff_drive_wheel_speed_ramp_tb;
  import ddws_pkg::*;

  localparam int unsigned SPEED_BITS     = 14;
  localparam int          IDLE_PCT       = 29;
  localparam int          RANDOM_PHASES  = 8;
  localparam int          PHASE_ITEMS    = 225;
  localparam int          DRAIN_CYCLES   = 150;
  localparam int          WATCHDOG_LIMIT = 4000;
  // index past the last register, written once to check it is ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_stall;
  logic [RAD_W-1:0]        turn_radius;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [RAD_W-1:0] applied_radius;
  logic [OUT_SPD_W-1:0]    right_speed;
  logic [OUT_SPD_W-1:0]    left_speed;
  logic [TIME_W-1:0]       right_ramp_ms;
  logic [TIME_W-1:0]       left_ramp_ms;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_data;
  int                      fail_count;
  int                      pending;
  int                      quiet_cycles = 0;
  logic                    calm = 1'b0;
  logic [BASE_W-1:0]       cur_base = RST_BASE;
  logic [LIMIT_W-1:0]      cur_limit = RST_LIMIT;
  logic [RAD_W-1:0]        last_radius = '0;

  diff_drive_wheel_speed_ramp #(.SPEED_BITS(SPEED_BITS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .turn_radius_i   (turn_radius),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .applied_radius_o(applied_radius),
    .right_speed_o   (right_speed),
    .left_speed_o    (left_speed),
    .right_ramp_ms_o (right_ramp_ms),
    .left_ramp_ms_o  (left_ramp_ms),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  diff_drive_wheel_speed_ramp_checker #(.SPEED_BITS(SPEED_BITS)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .turn_radius_i   (turn_radius),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .applied_radius_i(applied_radius),
    .right_speed_i   (right_speed),
    .left_speed_i    (left_speed),
    .right_ramp_ms_i (right_ramp_ms),
    .left_ramp_ms_i  (left_ramp_ms),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver stalls at random except in calm stretches
  always @(negedge clk_i) begin
    out_stall = calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    if (idx == CFG_BASE) cur_base = data[BASE_W-1:0];
    if (idx == CFG_LIMIT) cur_limit = data[LIMIT_W-1:0];
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] l,
                            input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] a,
                            input logic [CFG_DATA_W-1:0] m);
    write_reg(CFG_BASE, b);
    write_reg(CFG_LIMIT, l);
    write_reg(CFG_MSPD, s);
    write_reg(CFG_ACCEL, a);
    write_reg(CFG_MST, m);
  endtask

  // one radius transfer, with a random gap in front of it
  task automatic send_radius(input logic [RAD_W-1:0] r);
    logic done;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid    = 1'b0;
      turn_radius = RAD_W'($urandom);
      @(negedge clk_i);
    end
    in_valid    = 1'b1;
    turn_radius = r;
    last_radius = r;
    done = 1'b0;
    while (!done) begin
      @(posedge clk_i);
      done = !in_stall;
      @(negedge clk_i);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // radius mix: tiny values, repeats, values around the base, within the limit, anywhere, field extremes
  function automatic logic [RAD_W-1:0] pick_radius();
    int unsigned      kind;
    logic [RAD_W-1:0] mag;
    kind = $urandom_range(99);
    if (kind < 8) mag = RAD_W'($urandom_range(2));
    else if (kind < 22) return last_radius;
    else if (kind < 47) mag = RAD_W'($urandom_range(4 * cur_base + 8));
    else if (kind < 75) mag = RAD_W'($urandom_range(cur_limit));
    else if (kind < 92) return RAD_W'($urandom);
    else begin
      case ($urandom_range(2))
        0: mag = 21'd1000000;
        1: mag = 21'h0FFFFF;
        default: return 21'h100000;
      endcase
    end
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // random register setting per phase, extremes now and then
  task automatic random_config();
    logic [CFG_DATA_W-1:0] b, l, s, a, m;
    case ($urandom_range(9))
      0: b = CFG_DATA_W'($urandom);
      1: b = $urandom_range(1) ? 20'd10 : 20'd2047;
      default: b = CFG_DATA_W'($urandom_range(2000, 10));
    endcase
    case ($urandom_range(9))
      0: l = CFG_DATA_W'($urandom_range(20000, 100));
      1: l = CFG_DATA_W'($urandom);
      2: l = $urandom_range(1) ? 20'd100 : 20'd1000000;
      3, 4, 5: l = CFG_DATA_W'($urandom_range(1000000, 100));
      default: l = CFG_DATA_W'($urandom_range(20000, 100));
    endcase
    case ($urandom_range(9))
      0: s = CFG_DATA_W'($urandom);
      1: s = $urandom_range(1) ? 20'd0 : 20'd10000;
      default: s = CFG_DATA_W'($urandom_range(10000));
    endcase
    case ($urandom_range(9))
      0: a = CFG_DATA_W'($urandom);
      1: a = $urandom_range(1) ? 20'd1 : 20'd10000;
      2, 3, 4: a = CFG_DATA_W'($urandom_range(10000, 1));
      default: a = CFG_DATA_W'($urandom_range(200, 1));
    endcase
    case ($urandom_range(9))
      0: m = CFG_DATA_W'($urandom);
      1: m = $urandom_range(1) ? 20'd2 : 20'd65535;
      2, 3, 4: m = CFG_DATA_W'($urandom_range(65535, 2));
      default: m = CFG_DATA_W'($urandom_range(2000, 2));
    endcase
    set_config(b, l, s, a, m);
  endtask

  // stimulus
  initial begin
    rst_ni      = 1'b1;
    in_valid    = 1'b0;
    turn_radius = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    #1;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset setting: zero radius, field extremes, around the base, repeats
    send_radius(21'd0);
    send_radius(21'd1);
    send_radius(-21'sd1);
    send_radius(21'h0FFFFF);
    send_radius(21'h100000);
    send_radius(21'd300);
    send_radius(-21'sd301);
    send_radius(21'd10000);
    send_radius(21'd10000);
    send_radius(-21'sd5000);
    send_radius(21'd3000);
    drain();

    // base above the limit, largest registers, outer speed saturating
    write_reg(CFG_SPARE, 20'hFFFFF);
    set_config(20'd2000, 20'd100, 20'd16383, 20'd16383, 20'd65535);
    send_radius(21'd500);
    send_radius(-21'sd2000);
    send_radius(21'd0);
    drain();

    // zero limit, zero base with zero radius, zero acceleration, shortest s-curve
    set_config(20'd0, 20'd0, 20'd10000, 20'd0, 20'd2);
    send_radius(21'd0);
    send_radius(21'd7);
    send_radius(-21'sd7);
    send_radius(21'd0);
    drain();

    // widest limit, zero speed, smallest acceleration
    set_config(20'd10, 20'hFFFFF, 20'd0, 20'd1, 20'd3);
    send_radius(-21'sd1000000);
    send_radius(21'd1000000);
    send_radius(21'd12);
    drain();

    // random phases, one of them without any idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_config();
      calm = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) send_radius(pick_radius());
      drain();
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
